// ----- src/lmsp_pkg.sv -----
// Shared types and constants for the LED matrix scan and PWM core.
// Holds the opcode type, field widths, default geometry and the reset table
// of the present-pixel mask. No dependencies.
`timescale 1ns / 1ps

package lmsp_pkg;

    localparam int ROWS_DEF      = 24;
    localparam int COLUMNS_DEF   = 26;
    localparam int LEVEL_MAX_DEF = 15;

    // Fixed payload field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 5;
    localparam int DRIVE_W = 26;
    localparam int LEVEL_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_FRAME = 2'd1,
        OP_LEVEL = 2'd2,
        OP_MASK  = 2'd3
    } t_op;

    // Heart-shaped mask of physically fitted pixels; rows past it are full.
    function automatic logic [63:0] mask_reset(input int unsigned r);
        logic [63:0] v;
        case (r)
            0:       v = 64'h00F03C0;
            1:       v = 64'h03FCFF0;
            2:       v = 64'h07FFFF8;
            3:       v = 64'h0FFFFFC;
            4:       v = 64'h1FFFFFE;
            5:       v = 64'h1FFFFFE;
            6:       v = 64'h3FFFFFF;
            7:       v = 64'h3FFFFFF;
            8:       v = 64'h3FFFFFF;
            9:       v = 64'h3FFFFFF;
            10:      v = 64'h1FFFFFE;
            11:      v = 64'h1FFFFFE;
            12:      v = 64'h0FFFFFC;
            13:      v = 64'h07FFFF8;
            14:      v = 64'h03FFFF0;
            15:      v = 64'h01FFFE0;
            16:      v = 64'h00FFFC0;
            17:      v = 64'h007FF80;
            18:      v = 64'h003FF00;
            19:      v = 64'h001FE00;
            20:      v = 64'h000FC00;
            21:      v = 64'h0007800;
            22:      v = 64'h0003000;
            23:      v = 64'h3FFFFFF;
            default: v = '1;
        endcase
        return v;
    endfunction

endpackage

// ----- src/lmsp_level_mem.sv -----
// Per-pixel brightness store: one memory bank per column, ROWS deep.
// All banks read the same row in the same cycle; each bank has its own write enable.
// Depends on lmsp_pkg for default geometry.
`timescale 1ns / 1ps

module lmsp_level_mem #(
    parameter int ROWS    = lmsp_pkg::ROWS_DEF,
    parameter int COLUMNS = lmsp_pkg::COLUMNS_DEF,
    parameter int LW      = lmsp_pkg::LEVEL_W,
    localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                  i_clk,
    input  logic [COLUMNS-1:0]    i_we,
    input  logic [RW-1:0]         i_waddr,
    input  logic [LW-1:0]         i_wdata,
    input  logic                  i_re,
    input  logic [RW-1:0]         i_raddr,
    output logic [COLUMNS*LW-1:0] o_rdata
);

    for (genvar gc = 0; gc < COLUMNS; gc++) begin : g_bank
        logic [LW-1:0] r_bank [ROWS];
        logic [LW-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_we[gc]) begin
                r_bank[i_waddr] <= i_wdata;
            end
            if (i_re) begin
                r_rd <= r_bank[i_raddr];
            end
        end

        assign o_rdata[gc*LW +: LW] = r_rd;
    end

endmodule

// ----- src/led_matrix_scan_pwm_core.sv -----
// LED matrix scan and PWM core: top level.
// Uses lmsp_pkg and lmsp_level_mem (per-column brightness banks).
//
// Usage:
//   Input channel (i_valid / o_ready) carries one transaction per cycle when
//   ready: a tick or a write to the frame, pixel level or row mask store.
//   Writes produce no output. Each tick produces one output transaction
//   (o_valid / i_ready) describing one PWM slot: the selected row, its
//   enable, and column drives. A row gets LEVEL_MAX lit slots followed by
//   one blanking slot, then the scan moves to the next row and wraps after
//   ROWS rows. Pipeline: a tick accepted into the input register stage,
//   with the bank read at the accepting edge, moves on to the result
//   register once the output is free. Throughput: one transaction per cycle
//   when the output is not stalled and no clearing pass runs, set by the
//   registered read of the column banks; a write is visible to the next tick.
//   Reset: frame cleared, masks loaded from the fixed table, scan at row 0
//   slot 0. A clearing pass then loads LEVEL_MAX into every pixel level, one
//   row per cycle over all ROWS rows (24 by default); o_ready is low meanwhile.
//   Receiver stall: the result register holds, one more tick can be taken
//   into the input stage, then o_ready drops until the output drains.
`timescale 1ns / 1ps

module led_matrix_scan_pwm_core #(
    parameter int ROWS      = lmsp_pkg::ROWS_DEF,
    parameter int COLUMNS   = lmsp_pkg::COLUMNS_DEF,
    parameter int LEVEL_MAX = lmsp_pkg::LEVEL_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lmsp_pkg::OP_W-1:0]     i_op,
    input  logic [lmsp_pkg::IDX_W-1:0]    i_row,
    input  logic [lmsp_pkg::IDX_W-1:0]    i_column,
    input  logic [lmsp_pkg::DRIVE_W-1:0]  i_row_bits,
    input  logic [lmsp_pkg::LEVEL_W-1:0]  i_level,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lmsp_pkg::IDX_W-1:0]    o_row_index,
    output logic                          o_row_enable,
    output logic [lmsp_pkg::DRIVE_W-1:0]  o_column_drive
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW = $clog2(LEVEL_MAX + 1);
    localparam int LW = (SW > lmsp_pkg::LEVEL_W) ? SW : lmsp_pkg::LEVEL_W;
    localparam int DW = lmsp_pkg::DRIVE_W;

    // Handshake
    logic w_out_free, w_s1_free, w_accept, w_tick;
    lmsp_pkg::t_op w_op;
    logic w_row_ok, w_col_ok, w_blank;
    logic [RW-1:0] w_row_idx;
    logic [COLUMNS-1:0] w_bits;

    // State
    logic [COLUMNS-1:0] r_frame [ROWS];
    logic [COLUMNS-1:0] r_mask  [ROWS];
    logic [RW-1:0]      r_row;
    logic [SW-1:0]      r_slot;
    logic               r_clr_busy;
    logic [RW-1:0]      r_clr_row;

    // Stage 1
    logic               r_s1_valid;
    logic [RW-1:0]      r_s1_row;
    logic               r_s1_blank;
    logic [SW-1:0]      r_s1_slot;
    logic [COLUMNS-1:0] r_s1_lit;

    // Output register
    logic                           r_out_valid;
    logic [lmsp_pkg::IDX_W-1:0]     r_out_row;
    logic                           r_out_en;
    logic [DW-1:0]                  r_out_drive;

    // Level memory interface
    logic [COLUMNS-1:0]    w_mem_we;
    logic [RW-1:0]         w_mem_waddr;
    logic [LW-1:0]         w_mem_wdata;
    logic [COLUMNS*LW-1:0] w_mem_rdata;
    logic [COLUMNS-1:0]    w_hit;
    logic [DW-1:0]         w_drive;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign o_ready    = w_s1_free && !r_clr_busy;
    assign w_accept   = i_valid && o_ready;
    assign w_op       = lmsp_pkg::t_op'(i_op);
    assign w_tick     = w_accept && (w_op == lmsp_pkg::OP_TICK);
    assign w_row_ok   = {1'b0, i_row} < 6'(ROWS);
    assign w_col_ok   = {2'b00, i_column} < 7'(COLUMNS);
    assign w_row_idx  = i_row[RW-1:0];
    assign w_blank    = (r_slot == SW'(LEVEL_MAX));

    // Drop row_bits above the matrix width; columns past the field read zero
    for (genvar gc = 0; gc < COLUMNS; gc++) begin : g_bits
        if (gc < DW) begin : g_in
            assign w_bits[gc] = i_row_bits[gc];
        end else begin : g_zero
            assign w_bits[gc] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_frame[r] <= '0;
                r_mask[r]  <= COLUMNS'(lmsp_pkg::mask_reset(r));
            end
        end else if (w_accept && w_row_ok) begin
            case (w_op)
                lmsp_pkg::OP_FRAME: r_frame[w_row_idx] <= w_bits;
                lmsp_pkg::OP_MASK:  r_mask[w_row_idx]  <= w_bits;
                default: ;
            endcase
        end
    end

    // Scan position: advance slot per tick, next row after the blank slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_slot <= '0;
        end else if (w_tick) begin
            if (w_blank) begin
                r_slot <= '0;
                r_row  <= (r_row == RW'(ROWS - 1)) ? '0 : r_row + RW'(1);
            end else begin
                r_slot <= r_slot + SW'(1);
            end
        end
    end

    // Clearing pass over the level banks after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_row == RW'(ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_row <= r_clr_row + RW'(1);
            end
        end
    end

    for (genvar gc = 0; gc < COLUMNS; gc++) begin : g_we
        assign w_mem_we[gc] = r_clr_busy ||
            (w_accept && (w_op == lmsp_pkg::OP_LEVEL) && w_row_ok && w_col_ok &&
             ({2'b00, i_column} == 7'(gc)));
    end
    assign w_mem_waddr = r_clr_busy ? r_clr_row : w_row_idx;
    assign w_mem_wdata = r_clr_busy ? LW'(LEVEL_MAX) : LW'(i_level);

    lmsp_level_mem #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .LW      (LW)
    ) u_level_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_tick),
        .i_raddr (r_row),
        .o_rdata (w_mem_rdata)
    );

    // Stage 1: capture the slot and the row's lit pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_s1_row   <= r_row;
            r_s1_blank <= w_blank;
            r_s1_slot  <= r_slot;
            r_s1_lit   <= r_frame[r_row] & r_mask[r_row];
        end
    end

    for (genvar gc = 0; gc < COLUMNS; gc++) begin : g_hit
        assign w_hit[gc] = r_s1_lit[gc] && !r_s1_blank &&
                           (w_mem_rdata[gc*LW +: LW] > LW'(r_s1_slot));
    end

    for (genvar gd = 0; gd < DW; gd++) begin : g_drive
        if (gd < COLUMNS) begin : g_col
            assign w_drive[gd] = w_hit[gd];
        end else begin : g_none
            assign w_drive[gd] = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out_row   <= lmsp_pkg::IDX_W'(r_s1_row);
            r_out_en    <= !r_s1_blank;
            r_out_drive <= w_drive;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_row_index    = r_out_row;
    assign o_row_enable   = r_out_en;
    assign o_column_drive = r_out_drive;

`ifndef SYNTHESIS
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_ready)
        else $error("transaction accepted during level clearing pass");

    a_blank_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_row_enable) |-> (o_column_drive == '0))
        else $error("column drive active in blanking slot");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_row_index} < 6'(ROWS)))
        else $error("row index out of range");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SW'(LEVEL_MAX))
        else $error("PWM slot counter beyond blanking slot");

    a_blank_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick && w_blank) |=> (r_slot == '0))
        else $error("slot counter did not wrap after blanking slot");
`endif

endmodule
